[hdl/ball_flight_bounce_step_top_assert.svh]
// assertion macros for the ball flight stepper
`ifndef BALL_FLIGHT_BOUNCE_STEP_TOP_ASSERT_SVH
`define BALL_FLIGHT_BOUNCE_STEP_TOP_ASSERT_SVH
// implication checked on every clock while out of reset
`define BFB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define BFB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[hdl/bfb_pkg.sv]
// ------------------------------------------------------------------------
// bfb_pkg
// shared widths, register indexes, word limits, gravity constant and saturation
// ------------------------------------------------------------------------
package bfb_pkg;
    localparam int W = 32;
    localparam int F = 16;
    localparam int DTW = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PW = 2 * W + 2;

    localparam logic [CFG_IDX_W-1:0] REG_MAG_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRAG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REACH_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REACH_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SURF_Y = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_Y = 3'd7;

    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] GRAV = W'(10) << F;

    // saturate a full-product-width signed value to a word
    function automatic logic signed [W-1:0] sat66(input logic signed [PW-1:0] x);
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] lo;
        hi = PW'(WMAX);
        lo = PW'(WMIN);
        if (x > hi) sat66 = WMAX;
        else if (x < lo) sat66 = WMIN;
        else sat66 = x[W-1:0];
    endfunction
endpackage

[hdl/bfb_mul.sv]
// ------------------------------------------------------------------------
// bfb_mul
// shared signed multiplier with registered full-width product
// ------------------------------------------------------------------------
module bfb_mul import bfb_pkg::*; (
    input  logic                i_clk,
    input  logic signed [W:0]   i_a,
    input  logic signed [W:0]   i_b,
    output logic signed [PW-1:0] o_p
);
    logic signed [PW-1:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= PW'(i_a * i_b);
    end
    assign o_p = r_p;
endmodule

[hdl/ball_flight_bounce_step_top.sv]
// ------------------------------------------------------------------------
// ball_flight_bounce_step_top
// Fixed-point ball flight stepper with table bounce and floor stop.
// Input channel: i_valid / o_stall with opcode, time step and launch values.
// Output channel: o_valid / i_stall with the ball state after each transaction.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data, to be written by the user
// only while idle; the block itself does not enforce this.
// A launch, or a tick on a ball that is out, raises o_valid in the cycle
// after acceptance. A tick runs a sequencer over one shared 33x33
// multiplier and a bit-serial square root; each multiply product is
// registered in the multiplier before it is used. One transaction is in
// flight at a time; o_stall stays high from acceptance until the result
// is taken.
// Reset clears the ball state, out flag and registers to their reset values.
// While the receiver stalls the result holds and no new input is taken.
// ------------------------------------------------------------------------
module ball_flight_bounce_step_top import bfb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_opcode,
    input  logic [DTW-1:0]       i_time_step,
    input  logic signed [W-1:0]  i_start_x,
    input  logic signed [W-1:0]  i_start_y,
    input  logic signed [W-1:0]  i_start_z,
    input  logic signed [W-1:0]  i_start_vx,
    input  logic signed [W-1:0]  i_start_vy,
    input  logic signed [W-1:0]  i_start_vz,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [W-1:0]         i_cfg_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [W-1:0]  o_cur_x,
    output logic signed [W-1:0]  o_cur_y,
    output logic signed [W-1:0]  o_cur_z,
    output logic signed [W-1:0]  o_cur_vx,
    output logic signed [W-1:0]  o_cur_vy,
    output logic signed [W-1:0]  o_cur_vz,
    output logic                 o_is_out
);
    localparam int RAD_W = 2 * W;
    localparam int CNT_W = $clog2(W);

    localparam logic [5:0] S_IDLE = 6'd0;
    localparam logic [5:0] S_GRAV = 6'd1;
    localparam logic [5:0] S_GRAVW = 6'd2;
    localparam logic [5:0] S_C0A = 6'd3;
    localparam logic [5:0] S_C0B = 6'd4;
    localparam logic [5:0] S_C1A = 6'd5;
    localparam logic [5:0] S_C1B = 6'd6;
    localparam logic [5:0] S_C2A = 6'd7;
    localparam logic [5:0] S_C2B = 6'd8;
    localparam logic [5:0] S_C2W = 6'd9;
    localparam logic [5:0] S_D0 = 6'd10;
    localparam logic [5:0] S_D1 = 6'd11;
    localparam logic [5:0] S_D2 = 6'd12;
    localparam logic [5:0] S_D2W = 6'd13;
    localparam logic [5:0] S_SQ0 = 6'd14;
    localparam logic [5:0] S_SQ1 = 6'd15;
    localparam logic [5:0] S_SQ2 = 6'd16;
    localparam logic [5:0] S_SQW = 6'd17;
    localparam logic [5:0] S_ROOT = 6'd18;
    localparam logic [5:0] S_M = 6'd19;
    localparam logic [5:0] S_MW = 6'd20;
    localparam logic [5:0] S_S = 6'd21;
    localparam logic [5:0] S_SW = 6'd22;
    localparam logic [5:0] S_G0 = 6'd23;
    localparam logic [5:0] S_G1 = 6'd24;
    localparam logic [5:0] S_G2 = 6'd25;
    localparam logic [5:0] S_G2W = 6'd26;
    localparam logic [5:0] S_P0 = 6'd27;
    localparam logic [5:0] S_P1 = 6'd28;
    localparam logic [5:0] S_P2 = 6'd29;
    localparam logic [5:0] S_P2W = 6'd30;
    localparam logic [5:0] S_COLL = 6'd31;
    localparam logic [5:0] S_OUT = 6'd32;

    logic signed [W-1:0] r_mag_x, r_mag_y, r_mag_z, r_surf, r_floor;
    logic [W-1:0]        r_drag;
    logic [W-2:0]        r_reach_x, r_reach_z;
    logic signed [W-1:0] r_x, r_y, r_z, r_vx, r_vy, r_vz;
    logic                r_out;
    logic [5:0]          r_st;
    logic [DTW-1:0]      r_dt;
    logic signed [PW-1:0] r_t;
    logic signed [W-1:0] r_c0, r_c1, r_c2;
    logic [W+1:0]        r_rem;
    logic [RAD_W-1:0]    r_sq;
    logic [W-1:0]        r_root;
    logic [CNT_W-1:0]    r_cnt;
    logic [W-1:0]        r_m;
    logic [W-1:0]        r_s;

    logic signed [W:0]    w_a, w_b;
    logic signed [PW-1:0] w_p;
    logic signed [PW-1:0] w_ps;
    logic signed [PW-1:0] w_pd;
    logic [W:0]           w_dt;
    logic [W+1:0]         w_trial;
    logic [W+3:0]         w_rem2;
    logic [W-1:0]         w_ax, w_az;

    bfb_mul u_mul (.i_clk(i_clk), .i_a(w_a), .i_b(w_b), .o_p(w_p));

    assign w_dt = {{(W+1-DTW){1'b0}}, r_dt};
    assign w_ps = w_p >>> F;
    assign w_pd = w_p >>> DTW;

    // operand select for the shared multiplier
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_st)
            S_GRAV: begin w_a = {1'b0, GRAV}; w_b = w_dt; end
            S_C0A: begin w_a = {r_mag_y[W-1], r_mag_y}; w_b = {r_vz[W-1], r_vz}; end
            S_C0B: begin w_a = {r_mag_z[W-1], r_mag_z}; w_b = {r_vy[W-1], r_vy}; end
            S_C1A: begin w_a = {r_mag_z[W-1], r_mag_z}; w_b = {r_vx[W-1], r_vx}; end
            S_C1B: begin w_a = {r_mag_x[W-1], r_mag_x}; w_b = {r_vz[W-1], r_vz}; end
            S_C2A: begin w_a = {r_mag_x[W-1], r_mag_x}; w_b = {r_vy[W-1], r_vy}; end
            S_C2B: begin w_a = {r_mag_y[W-1], r_mag_y}; w_b = {r_vx[W-1], r_vx}; end
            S_D0: begin w_a = {r_c0[W-1], r_c0}; w_b = w_dt; end
            S_D1: begin w_a = {r_c1[W-1], r_c1}; w_b = w_dt; end
            S_D2: begin w_a = {r_c2[W-1], r_c2}; w_b = w_dt; end
            S_SQ0: begin w_a = {r_vx[W-1], r_vx}; w_b = {r_vx[W-1], r_vx}; end
            S_SQ1: begin w_a = {r_vy[W-1], r_vy}; w_b = {r_vy[W-1], r_vy}; end
            S_SQ2: begin w_a = {r_vz[W-1], r_vz}; w_b = {r_vz[W-1], r_vz}; end
            S_M: begin w_a = {1'b0, r_drag}; w_b = w_dt; end
            S_S: begin w_a = {1'b0, r_root}; w_b = {1'b0, r_m}; end
            S_G0: begin w_a = {r_vx[W-1], r_vx}; w_b = {1'b0, r_s}; end
            S_G1: begin w_a = {r_vy[W-1], r_vy}; w_b = {1'b0, r_s}; end
            S_G2: begin w_a = {r_vz[W-1], r_vz}; w_b = {1'b0, r_s}; end
            S_P0: begin w_a = {r_vx[W-1], r_vx}; w_b = w_dt; end
            S_P1: begin w_a = {r_vy[W-1], r_vy}; w_b = w_dt; end
            S_P2: begin w_a = {r_vz[W-1], r_vz}; w_b = w_dt; end
            default: begin w_a = '0; w_b = '0; end
        endcase
    end

    // one root bit per cycle, two radicand bits shifted in
    assign w_rem2 = {r_rem, r_sq[RAD_W-1:RAD_W-2]};
    assign w_trial = {r_root, 2'b01};
    assign w_ax = r_x[W-1] ? W'(-r_x) : r_x;
    assign w_az = r_z[W-1] ? W'(-r_z) : r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_mag_x <= '0;
            r_mag_y <= '0;
            r_mag_z <= '0;
            r_drag <= '0;
            r_reach_x <= (W-1)'(98304);
            r_reach_z <= (W-1)'(49152);
            r_surf <= '0;
            r_floor <= -W'(49152);
            r_x <= '0;
            r_y <= '0;
            r_z <= '0;
            r_vx <= '0;
            r_vy <= '0;
            r_vz <= '0;
            r_out <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MAG_X: r_mag_x <= i_cfg_data;
                    REG_MAG_Y: r_mag_y <= i_cfg_data;
                    REG_MAG_Z: r_mag_z <= i_cfg_data;
                    REG_DRAG: r_drag <= i_cfg_data;
                    REG_REACH_X: r_reach_x <= i_cfg_data[W-2:0];
                    REG_REACH_Z: r_reach_z <= i_cfg_data[W-2:0];
                    REG_SURF_Y: r_surf <= i_cfg_data;
                    REG_FLOOR_Y: r_floor <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_dt <= i_time_step;
                        if (i_opcode) begin
                            r_x <= i_start_x;
                            r_y <= i_start_y;
                            r_z <= i_start_z;
                            r_vx <= i_start_vx;
                            r_vy <= i_start_vy;
                            r_vz <= i_start_vz;
                            r_out <= 1'b0;
                            r_st <= S_OUT;
                        end else if (r_out) begin
                            r_st <= S_OUT;
                        end else begin
                            r_st <= S_GRAV;
                        end
                    end
                end
                S_GRAV: r_st <= S_GRAVW;
                S_GRAVW: begin
                    r_vy <= sat66(PW'(r_vy) - w_pd);
                    r_st <= S_C0A;
                end
                S_C0A: r_st <= S_C0B;
                S_C0B: begin r_t <= w_ps; r_st <= S_C1A; end
                S_C1A: begin
                    r_c0 <= sat66(r_t - w_ps);
                    r_st <= S_C1B;
                end
                S_C1B: begin r_t <= w_ps; r_st <= S_C2A; end
                S_C2A: begin
                    r_c1 <= sat66(r_t - w_ps);
                    r_st <= S_C2B;
                end
                S_C2B: begin r_t <= w_ps; r_st <= S_C2W; end
                S_C2W: begin
                    r_c2 <= sat66(r_t - w_ps);
                    r_st <= S_D0;
                end
                S_D0: r_st <= S_D1;
                S_D1: begin r_vx <= sat66(PW'(r_vx) + w_pd); r_st <= S_D2; end
                S_D2: begin r_vy <= sat66(PW'(r_vy) + w_pd); r_st <= S_D2W; end
                S_D2W: begin r_vz <= sat66(PW'(r_vz) + w_pd); r_st <= S_SQ0; end
                S_SQ0: r_st <= S_SQ1;
                S_SQ1: begin r_sq <= RAD_W'(w_p); r_st <= S_SQ2; end
                S_SQ2: begin r_sq <= r_sq + RAD_W'(w_p); r_st <= S_SQW; end
                S_SQW: begin
                    r_sq <= r_sq + RAD_W'(w_p);
                    r_rem <= '0;
                    r_root <= '0;
                    r_cnt <= '0;
                    r_st <= S_ROOT;
                end
                S_ROOT: begin
                    r_sq <= {r_sq[RAD_W-3:0], 2'b00};
                    if (w_rem2 >= (W+4)'(w_trial)) begin
                        r_rem <= (W+2)'(w_rem2 - (W+4)'(w_trial));
                        r_root <= {r_root[W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rem2[W+1:0];
                        r_root <= {r_root[W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(W-1)) r_st <= S_M;
                end
                S_M: r_st <= S_MW;
                S_MW: begin r_m <= w_p[W+DTW-1:DTW]; r_st <= S_S; end
                S_S: r_st <= S_SW;
                S_SW: begin
                    if (w_ps > PW'(WMAX)) r_s <= WMAX;
                    else r_s <= w_ps[W-1:0];
                    r_st <= S_G0;
                end
                S_G0: r_st <= S_G1;
                S_G1: begin r_vx <= sat66(PW'(r_vx) - PW'(sat66(w_ps))); r_st <= S_G2; end
                S_G2: begin r_vy <= sat66(PW'(r_vy) - PW'(sat66(w_ps))); r_st <= S_G2W; end
                S_G2W: begin r_vz <= sat66(PW'(r_vz) - PW'(sat66(w_ps))); r_st <= S_P0; end
                S_P0: r_st <= S_P1;
                S_P1: begin r_x <= sat66(PW'(r_x) + w_pd); r_st <= S_P2; end
                S_P2: begin r_y <= sat66(PW'(r_y) + w_pd); r_st <= S_P2W; end
                S_P2W: begin r_z <= sat66(PW'(r_z) + w_pd); r_st <= S_COLL; end
                S_COLL: begin
                    if (w_ax < {1'b0, r_reach_x} && w_az < {1'b0, r_reach_z}) begin
                        if (r_y < r_surf && r_vy[W-1]) begin
                            r_y <= r_surf;
                            r_vy <= (r_vy == WMIN) ? WMAX : -r_vy;
                        end
                    end else if (r_y < r_floor) begin
                        r_y <= r_floor;
                        r_out <= 1'b1;
                    end
                    r_st <= S_OUT;
                end
                S_OUT: if (!i_stall) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_st != S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_cur_x = r_x;
    assign o_cur_y = r_y;
    assign o_cur_z = r_z;
    assign o_cur_vx = r_vx;
    assign o_cur_vy = r_vy;
    assign o_cur_vz = r_vz;
    assign o_is_out = r_out;

    `include "ball_flight_bounce_step_top_assert.svh"
    `BFB_ASSERT_NXT(a_launch_out, (r_st == S_IDLE) && i_valid && i_opcode, o_valid && !o_is_out)
    `BFB_ASSERT_IMP(a_valid_stall, o_valid, o_stall)
    `BFB_ASSERT_NXT(a_hold, o_valid && i_stall, o_valid && $stable(o_cur_y))
    `BFB_ASSERT_NXT(a_root_end, (r_st == S_ROOT) && (r_cnt == CNT_W'(W-1)), r_st == S_M)
endmodule

[bench/tb_ball_flight_bounce_step_top.sv]
// ------------------------------------------------------------------------
// tb_ball_flight_bounce_step_top
// Self-checking bench for the fixed-point ball flight stepper.
// A directed table covers reset state, word extremes, bounce, floor stop,
// frozen ball and ignored fields. Random launch-and-tick runs follow under
// several register settings and idle patterns. Every result is checked
// against the table's value where given, else an in-bench stepper model.
// ------------------------------------------------------------------------
module tb_ball_flight_bounce_step_top;
    import bfb_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [31:0] PMAX = 32'h7fffffff;
    localparam logic [31:0] PMIN = 32'h80000000;
    localparam bit OP_TICK = 1'b0;
    localparam bit OP_LAUNCH = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] dt;
        logic [31:0] sx, sy, sz, svx, svy, svz;
    } item_t;

    typedef struct packed {
        logic [31:0] x, y, z, vx, vy, vz;
        logic        out;
    } ball_t;

    typedef struct packed {
        item_t it;
        logic  typed;
        ball_t want;
    } row_t;

    logic                 i_clk, i_rst_n, i_valid, i_opcode, i_cfg_we, i_stall;
    logic [DTW-1:0]       i_time_step;
    logic signed [W-1:0]  i_start_x, i_start_y, i_start_z;
    logic signed [W-1:0]  i_start_vx, i_start_vy, i_start_vz;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [W-1:0]         i_cfg_data;
    logic                 o_stall, o_valid, o_is_out;
    logic signed [W-1:0]  o_cur_x, o_cur_y, o_cur_z, o_cur_vx, o_cur_vy, o_cur_vz;

    ball_flight_bounce_step_top dut (.*);

    // model state and registers
    longint bx, by, bz, bvx, bvy, bvz;
    bit     bout;
    longint spin_x, spin_y, spin_z, surf_y, floor_lvl;
    longint unsigned drag, reach_x, reach_z;

    ball_t  ball_q[$];
    int     errors, n_items, n_results, n_launch, n_out, hold_len;
    int     send_pct, stall_pct, cycles;

    row_t dir_tab[] = '{
        '{'{OP_TICK, 16'h0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0, 0, 0}},
        '{'{OP_LAUNCH, 16'h1234, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX}, 1,
          '{PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, 0}},
        '{'{OP_TICK, 16'hffff, 0, 0, 0, 0, 0, 0}, 0, '0},
        '{'{OP_LAUNCH, 16'h0, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN}, 1,
          '{PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, 0}},
        '{'{OP_TICK, 16'hffff, 0, 0, 0, 0, 0, 0}, 0, '0},
        '{'{OP_LAUNCH, 16'h0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0, 0, 0}},
        '{'{OP_TICK, 16'h0, 32'hdeadbeef, PMAX, PMIN, 32'h5a5a5a5a, 32'ha5a5a5a5, 32'h1},
          1, '{0, 0, 0, 0, 0, 0, 0}},
        '{'{OP_TICK, 16'h0100, 0, 0, 0, 0, 0, 0}, 0, '0},
        '{'{OP_LAUNCH, 16'h0, 0, 32'h100, 0, 32'h8000, 32'hfffe0000, 0}, 0, '0},
        '{'{OP_TICK, 16'h2000, 0, 0, 0, 0, 0, 0}, 0, '0},
        '{'{OP_LAUNCH, 16'h0, 32'h40000, 0, 0, 0, 32'hfffc0000, 0}, 0, '0},
        '{'{OP_TICK, 16'h8000, 0, 0, 0, 0, 0, 0}, 0, '0},
        '{'{OP_TICK, 16'hffff, 0, 0, 0, 0, 0, 0}, 0, '0},
        '{'{OP_LAUNCH, 16'hffff, 32'h10000, 32'h20000, 0, 32'h30000, 32'h10000,
          32'hffff0000}, 1, '{32'h10000, 32'h20000, 0, 32'h30000, 32'h10000,
          32'hffff0000, 0}},
        '{'{OP_TICK, 16'h0001, 0, 0, 0, 0, 0, 0}, 0, '0},
        '{'{OP_LAUNCH, 16'h0, 32'hfffe8000, 32'hffffffff, 32'h0000bfff, 0, PMIN, 0},
          0, '0},
        '{'{OP_TICK, 16'h4000, 0, 0, 0, 0, 0, 0}, 0, '0},
        '{'{OP_TICK, 16'h4000, 0, 0, 0, 0, 0, 0}, 0, '0}
    };

    function automatic longint sat_word(longint v);
        if (v > 64'sh7fffffff) return 64'sh7fffffff;
        if (v < -64'sh80000000) return -64'sh80000000;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000000000000000;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void fly_ball(longint dt);
        longint c0, c1, c2, v[3], ax, az;
        longint unsigned mag, m, s;
        bvy = sat_word(bvy - (((longint'(10) << 16) * dt) >>> 16));
        c0 = sat_word(((spin_y * bvz) >>> 16) - ((spin_z * bvy) >>> 16));
        c1 = sat_word(((spin_z * bvx) >>> 16) - ((spin_x * bvz) >>> 16));
        c2 = sat_word(((spin_x * bvy) >>> 16) - ((spin_y * bvx) >>> 16));
        v[0] = sat_word(bvx + ((c0 * dt) >>> 16));
        v[1] = sat_word(bvy + ((c1 * dt) >>> 16));
        v[2] = sat_word(bvz + ((c2 * dt) >>> 16));
        mag = int_sqrt(longint'(unsigned'(v[0] * v[0])) + unsigned'(v[1] * v[1])
                       + unsigned'(v[2] * v[2]));
        m = (drag * longint'(unsigned'(dt))) >> 16;
        s = (mag * m) >> 16;
        if (s > 64'h7fffffff) s = 64'h7fffffff;
        for (int i = 0; i < 3; i++)
            v[i] = sat_word(v[i] - sat_word((v[i] * longint'(s)) >>> 16));
        bvx = v[0];
        bvy = v[1];
        bvz = v[2];
        bx = sat_word(bx + ((bvx * dt) >>> 16));
        by = sat_word(by + ((bvy * dt) >>> 16));
        bz = sat_word(bz + ((bvz * dt) >>> 16));
        ax = bx < 0 ? -bx : bx;
        az = bz < 0 ? -bz : bz;
        if (ax < longint'(reach_x) && az < longint'(reach_z)) begin
            if (by < surf_y && bvy < 0) begin
                by = surf_y;
                bvy = sat_word(-bvy);
            end
        end else if (by < floor_lvl) begin
            by = floor_lvl;
            bout = 1;
        end
    endfunction

    function automatic ball_t step_ball(item_t it);
        if (it.op == OP_LAUNCH) begin
            bx = longint'($signed(it.sx));
            by = longint'($signed(it.sy));
            bz = longint'($signed(it.sz));
            bvx = longint'($signed(it.svx));
            bvy = longint'($signed(it.svy));
            bvz = longint'($signed(it.svz));
            bout = 0;
        end else if (!bout) begin
            fly_ball(longint'(it.dt));
        end
        return '{bx[31:0], by[31:0], bz[31:0], bvx[31:0], bvy[31:0], bvz[31:0], bout};
    endfunction

    function automatic void reset_model();
        {spin_x, spin_y, spin_z, drag, surf_y} = '0;
        reach_x = 98304;
        reach_z = 49152;
        floor_lvl = -49152;
        {bx, by, bz, bvx, bvy, bvz} = '0;
        bout = 0;
    endfunction

    function automatic logic [31:0] rnd_span(int unsigned r);
        return 32'($urandom_range(2 * r)) - r;
    endfunction

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still awaited", $time, ball_q.size());
            $display("ball_flight_bounce_step_top regression: fail");
            $finish;
        end
    end

    // receiver stall, with long hold-offs counted here
    initial begin
        i_stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                i_stall = 1;
                hold_len--;
            end else begin
                i_stall = $urandom_range(99) < stall_pct;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        ball_t got, want;
        logic [31:0] g[7], w[7];
        string nm[7];
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            got = '{o_cur_x, o_cur_y, o_cur_z, o_cur_vx, o_cur_vy, o_cur_vz, o_is_out};
            if (ball_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, actual %h", $time, got);
            end else begin
                want = ball_q.pop_front();
                nm = '{"x", "y", "z", "vx", "vy", "vz", "is_out"};
                g = '{got.x, got.y, got.z, got.vx, got.vy, got.vz, 32'(got.out)};
                w = '{want.x, want.y, want.z, want.vx, want.vy, want.vz, 32'(want.out)};
                for (int i = 0; i < 7; i++)
                    if (g[i] !== w[i]) begin
                        errors++;
                        $display("%0t: %s mismatch, expected %h actual %h",
                                 $time, nm[i], w[i], g[i]);
                    end
            end
        end
    end

    task automatic send_item(item_t it, logic typed, ball_t want);
        ball_t pred;
        while ($urandom_range(99) < send_pct) begin
            i_valid = 0;
            @(negedge i_clk);
        end
        i_opcode = it.op;
        i_time_step = it.dt;
        {i_start_x, i_start_y, i_start_z} = {it.sx, it.sy, it.sz};
        {i_start_vx, i_start_vy, i_start_vz} = {it.svx, it.svy, it.svz};
        i_valid = 1;
        do @(posedge i_clk); while (o_stall);
        pred = step_ball(it);
        ball_q.push_back(typed ? want : pred);
        n_items++;
        if (it.op == OP_LAUNCH) n_launch++;
        if (pred.out) n_out++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid = 0;
        while (ball_q.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 0;
        case (idx)
            REG_MAG_X:   spin_x = longint'($signed(data));
            REG_MAG_Y:   spin_y = longint'($signed(data));
            REG_MAG_Z:   spin_z = longint'($signed(data));
            REG_DRAG:    drag = data;
            REG_REACH_X: reach_x = data & PMAX;
            REG_REACH_Z: reach_z = data & PMAX;
            REG_SURF_Y:  surf_y = longint'($signed(data));
            REG_FLOOR_Y: floor_lvl = longint'($signed(data));
            default: ;
        endcase
    endtask

    task automatic set_regs(int ph);
        logic [31:0] d[8];
        case (ph)
            1: d = '{rnd_span(32'h8000), rnd_span(32'h8000), rnd_span(32'h8000),
                     $urandom_range(32'h4000), 32'h18000, 32'hc000, 0, 32'hffff4000};
            2: d = '{PMAX, PMAX, PMAX, 32'hffffffff, PMAX, 32'hffffffff, PMIN, PMIN};
            3: d = '{PMIN, PMIN, PMIN, 0, 0, 0, PMAX, PMAX};
            4: d = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom};
            default: d = '{rnd_span(32'h30000), rnd_span(32'h30000), rnd_span(32'h30000),
                           $urandom_range(32'h20000), $urandom_range(32'h40000),
                           $urandom_range(32'h40000), rnd_span(32'h10000),
                           rnd_span(32'h20000) - 32'h10000};
        endcase
        for (int i = 0; i < 8; i++) write_reg(CFG_IDX_W'(i), d[i]);
    endtask

    task automatic random_flights(int count, int ph);
        item_t it;
        int ticks;
        int k;
        k = 0;
        while (k < count) begin
            it = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom});
            if ($urandom_range(9) == 0) begin
                send_item(it, 0, '0);
                k++;
            end else begin
                it.op = OP_LAUNCH;
                if ($urandom_range(99) >= 15) begin
                    it.sx = rnd_span(32'h20000);
                    it.sy = $urandom_range(32'h20000);
                    it.sz = rnd_span(32'h10000);
                    it.svx = rnd_span(32'h80000);
                    it.svy = rnd_span(32'h80000);
                    it.svz = rnd_span(32'h80000);
                end
                send_item(it, 0, '0);
                ticks = $urandom_range(15, 3);
                k += ticks + 1;
                repeat (ticks) begin
                    it = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom});
                    it.op = OP_TICK;
                    if ($urandom_range(4) != 0) it.dt = $urandom_range(16'h1000);
                    send_item(it, 0, '0);
                end
            end
            if (ph == 1 && k >= 40 && k < 60 && hold_len == 0) hold_len = 400;
            if (ph == 2 && k >= 50 && k < 66) wait_drained();
        end
    endtask

    initial begin
        {i_valid, i_opcode, i_time_step, i_cfg_we, i_cfg_idx, i_cfg_data} = '0;
        {i_start_x, i_start_y, i_start_z, i_start_vx, i_start_vy, i_start_vz} = '0;
        {errors, n_items, n_results, n_launch, n_out, hold_len, cycles} = '0;
        {send_pct, stall_pct} = '0;
        reset_model();
        i_rst_n = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);
        foreach (dir_tab[r]) send_item(dir_tab[r].it, dir_tab[r].typed, dir_tab[r].want);
        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            if (ph != 0) set_regs(ph);
            case (ph % 4)
                0: begin send_pct = 0;  stall_pct = 0;  end
                1: begin send_pct = 73; stall_pct = 0;  end
                2: begin send_pct = 0;  stall_pct = 73; end
                default: begin send_pct = 22; stall_pct = 22; end
            endcase
            random_flights(100, ph);
        end
        i_valid = 0;
        while (ball_q.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        $display("covered %0d transactions (%0d launches, %0d ending out), %0d results",
                 n_items, n_launch, n_out, n_results);
        $display("six register settings incl. word extremes, four idle patterns");
        if (errors == 0 && ball_q.size() == 0) begin
            $display("ball_flight_bounce_step_top regression: pass");
        end else begin
            $display("ball_flight_bounce_step_top regression: fail");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+hdl
hdl/bfb_pkg.sv
hdl/bfb_mul.sv
hdl/ball_flight_bounce_step_top.sv
bench/tb_ball_flight_bounce_step_top.sv
